### sv/caei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caei_pkg
// Widths, angle constants and CORDIC helpers of the circular arc edge
// interpolator.
// ----------------------------------------------------------------------------
package caei_pkg;

  localparam int ITER   = 24;   // CORDIC steps, angle and rotation alike
  localparam int AW     = 36;   // angle width, signed radians with 30 fraction bits
  localparam int RW     = 34;   // rotation x,y width
  localparam int DW     = 36;   // divider dividend width
  localparam int IN_W   = 192;  // six 32 bit coordinates
  localparam int OUT_W  = 104;  // three coordinates, index, one pad bit
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_X = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y = 2'd2;
  localparam logic [CFG_AW-1:0] REG_PPE      = 2'd3;

  localparam logic [6:0] PPE_RESET = 7'd5;
  localparam logic [6:0] MAX_NODES = 7'd66;
  localparam logic [6:0] MIN_NODES = 7'd3;

  localparam logic signed [AW-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic [29:0]          GAIN_INV    = 30'd652032874;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
  } vec_t;

  function automatic logic signed [AW-1:0] atan_step(input logic [4:0] i);
    logic signed [AW-1:0] r;
    r = '0;
    unique case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      default: begin
        if (i <= 5'd30) begin
          r = AW'(1) << (5'd30 - i);
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

  // One vectoring step: drives y toward zero and collects the angle in z.
  function automatic vec_t vec_step(input vec_t v, input logic [4:0] i);
    logic signed [AW-1:0] xs;
    logic signed [AW-1:0] ys;
    vec_t r;
    xs = v.x >>> i;
    ys = v.y >>> i;
    r = v;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + atan_step(i);
    end else if (v.y < 0) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - atan_step(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/circular_arc_edge_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_arc_edge_interpolator_core
// Takes the two end points of an edge, finds their angles about the cylinder
// axis and streams the interior points of the arc between them.
//
//   Channel  Direction  Content
//   s_axis   in         one edge: start x,y,z and end x,y,z
//   m_axis   out        one interior point: x, y, z, index; tlast on the last
//   cfg      in         radius, center_x, center_y, points_per_edge
//
// An edge is taken only in idle. Setup runs the angle CORDIC, then wrap and
// preparation, then the bit serial divider. The points then leave at one per
// cycle, while m_axis does not stall, through a 29 stage pipeline: issue,
// wrap, fold, 24 rotation steps, unfold and output register. The next edge is
// taken once the last point of the previous one is issued, even while its
// points are still in the pipeline. A stall at m_axis freezes the point
// pipeline and the issue of points. Reset is synchronous.
// ----------------------------------------------------------------------------
module circular_arc_edge_interpolator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [caei_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // point_x, point_y, point_z, point_index, one zero bit
  output logic [caei_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [caei_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [31:0]                   cfg_wdata
);
  import caei_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ANGLE  = 6'b000010,
    ST_WRAP   = 6'b000100,
    ST_PREP   = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state;

  logic [30:0] radius;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [6:0]  ppe;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= '0;
      center_x <= '0;
      center_y <= '0;
      ppe      <= PPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS:   radius   <= cfg_wdata[30:0];
        REG_CENTER_X: center_x <= cfg_wdata;
        REG_CENTER_Y: center_y <= cfg_wdata;
        REG_PPE:      ppe      <= cfg_wdata[6:0];
        default:      ppe      <= ppe;
      endcase
    end
  end

  logic en;
  logic out_valid;
  assign en = !out_valid || m_axis_tready;

  // Setup registers.
  logic [5:0]  iter;
  vec_t        a0;
  vec_t        a1;
  logic [6:0]  cnt;
  logic [6:0]  dvs;
  logic [31:0] sz;
  logic [31:0] ez;
  logic [30:0] r0;
  logic        neg_t;
  logic        neg_z;
  logic [DW-1:0] num_t;
  logic [DW-1:0] num_z;
  logic [6:0]  rem_t;
  logic [6:0]  rem_z;
  logic [DW-1:0] acc_qt;
  logic [DW-1:0] acc_qz;
  logic [6:0]  acc_rt;
  logic [6:0]  acc_rz;
  logic [6:0]  k;

  logic [6:0]  n_eff;
  vec_t        v0_init;
  vec_t        v1_init;
  vec_t        v0_step;
  vec_t        v1_step;
  logic signed [AW-1:0] dt;
  logic signed [32:0]   dz;
  logic [60:0] r_prod;
  logic [60:0] r_rnd;
  logic [7:0]  sh_t;
  logic [7:0]  sh_z;
  logic        qb_t;
  logic        qb_z;
  logic [7:0]  rs_t;
  logic [7:0]  rs_z;
  logic        c_t;
  logic        c_z;
  logic [DW-1:0] qn_t;
  logic [DW-1:0] qn_z;
  logic [6:0]  rn_t;
  logic [6:0]  rn_z;

  function automatic vec_t vec_init(input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] cx, input logic [31:0] cy);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    vec_t r;
    dx = $signed({px[31], px}) - $signed({cx[31], cx});
    dy = $signed({py[31], py}) - $signed({cy[31], cy});
    if (dx < 0) begin
      r.x = -AW'(dx);
      r.y = -AW'(dy);
      r.z = (dy >= 0) ? ANG_PI : -ANG_PI;
    end else begin
      r.x = AW'(dx);
      r.y = AW'(dy);
      r.z = '0;
    end
    return r;
  endfunction

  always_comb begin
    n_eff   = (ppe > MAX_NODES) ? MAX_NODES : ppe;
    v0_init = vec_init(s_axis_tdata[31:0], s_axis_tdata[63:32], center_x, center_y);
    v1_init = vec_init(s_axis_tdata[127:96], s_axis_tdata[159:128], center_x, center_y);
    v0_step = vec_step(a0, iter[4:0]);
    v1_step = vec_step(a1, iter[4:0]);
    dt      = a1.z - a0.z;
    dz      = $signed({ez[31], ez}) - $signed({sz[31], sz});
    r_prod  = 61'(radius) * 61'(GAIN_INV);
    r_rnd   = r_prod + (61'd1 << 29);
    sh_t    = {rem_t, num_t[DW-1]};
    sh_z    = {rem_z, num_z[DW-1]};
    qb_t    = sh_t >= {1'b0, dvs};
    qb_z    = sh_z >= {1'b0, dvs};
    rs_t    = {1'b0, acc_rt} + {1'b0, rem_t};
    rs_z    = {1'b0, acc_rz} + {1'b0, rem_z};
    c_t     = rs_t >= {1'b0, dvs};
    c_z     = rs_z >= {1'b0, dvs};
    qn_t    = acc_qt + num_t + DW'(c_t);
    qn_z    = acc_qz + num_z + DW'(c_z);
    rn_t    = c_t ? 7'(rs_t - {1'b0, dvs}) : rs_t[6:0];
    rn_z    = c_z ? 7'(rs_z - {1'b0, dvs}) : rs_z[6:0];
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          iter <= '0;
          if (s_axis_tvalid && n_eff >= MIN_NODES) begin
            state <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          if (iter == 6'(ITER - 1)) begin
            state <= ST_WRAP;
            iter  <= '0;
          end else begin
            iter <= iter + 6'd1;
          end
        end
        ST_WRAP:   state <= ST_PREP;
        ST_PREP:   state <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (iter == 6'(DW - 1)) begin
            state <= ST_EMIT;
            iter  <= '0;
          end else begin
            iter <= iter + 6'd1;
          end
        end
        ST_EMIT: begin
          if (en && k == cnt) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        a0  <= v0_init;
        a1  <= v1_init;
        cnt <= n_eff - 7'd2;
        dvs <= n_eff - 7'd1;
        sz  <= s_axis_tdata[95:64];
        ez  <= s_axis_tdata[191:160];
      end
      ST_ANGLE: begin
        a0 <= v0_step;
        a1 <= v1_step;
      end
      ST_WRAP: begin
        // Keep the arc on the short side across the negative x axis.
        if (a0.z < -ANG_HALF_PI && a1.z > 0) begin
          a0.z <= a0.z + ANG_TWO_PI;
        end else if (a1.z < -ANG_HALF_PI && a0.z > 0) begin
          a1.z <= a1.z + ANG_TWO_PI;
        end
      end
      ST_PREP: begin
        neg_t  <= dt < 0;
        num_t  <= (dt < 0) ? DW'(-dt) : DW'(dt);
        neg_z  <= dz < 0;
        num_z  <= (dz < 0) ? DW'(-dz) : DW'(dz);
        rem_t  <= '0;
        rem_z  <= '0;
        r0     <= r_rnd[60:30];
        acc_qt <= '0;
        acc_qz <= '0;
        acc_rt <= dvs >> 1;
        acc_rz <= dvs >> 1;
        k      <= 7'd1;
      end
      ST_DIVIDE: begin
        rem_t <= qb_t ? 7'(sh_t - {1'b0, dvs}) : sh_t[6:0];
        rem_z <= qb_z ? 7'(sh_z - {1'b0, dvs}) : sh_z[6:0];
        num_t <= {num_t[DW-2:0], qb_t};
        num_z <= {num_z[DW-2:0], qb_z};
      end
      ST_EMIT: begin
        if (en) begin
          acc_qt <= qn_t;
          acc_qz <= qn_z;
          acc_rt <= rn_t;
          acc_rz <= rn_z;
          k      <= k + 7'd1;
        end
      end
      default: k <= k;
    endcase
  end

  // Issue stage: angle and z of point k.
  logic                 iss_valid;
  logic signed [AW-1:0] iss_t;
  logic [31:0]          iss_z;
  logic [6:0]           iss_idx;
  logic                 iss_last;
  logic [33:0]          z_sum;

  always_comb begin
    z_sum = {{2{sz[31]}}, sz} + (neg_z ? -qn_z[33:0] : qn_z[33:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
    end else if (en) begin
      iss_valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iss_t    <= a0.z + (neg_t ? -$signed(qn_t) : $signed(qn_t));
      iss_z    <= z_sum[31:0];
      iss_idx  <= k;
      iss_last <= (k == cnt);
    end
  end

  // Wrap stage: angle into -pi..pi.
  logic                 wr_valid;
  logic signed [AW-1:0] wr_t;
  logic [31:0]          wr_z;
  logic [6:0]           wr_idx;
  logic                 wr_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (en) begin
      wr_valid <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (iss_t > ANG_PI) begin
        wr_t <= iss_t - ANG_TWO_PI;
      end else if (iss_t < -ANG_PI) begin
        wr_t <= iss_t + ANG_TWO_PI;
      end else begin
        wr_t <= iss_t;
      end
      wr_z    <= iss_z;
      wr_idx  <= iss_idx;
      wr_last <= iss_last;
    end
  end

  // Rotation pipeline; entry 0 holds the half plane fold.
  logic                 pv [0:ITER];
  logic signed [RW-1:0] px [0:ITER];
  logic signed [RW-1:0] py [0:ITER];
  logic signed [AW-1:0] pt [0:ITER];
  logic [31:0]          pz [0:ITER];
  logic [6:0]           pidx [0:ITER];
  logic                 plast [0:ITER];
  logic                 pflip [0:ITER];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (en) begin
      pv[0] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= {3'b000, r0};
      py[0] <= '0;
      if (wr_t > ANG_HALF_PI) begin
        pt[0]    <= wr_t - ANG_PI;
        pflip[0] <= 1'b1;
      end else if (wr_t < -ANG_HALF_PI) begin
        pt[0]    <= wr_t + ANG_PI;
        pflip[0] <= 1'b1;
      end else begin
        pt[0]    <= wr_t;
        pflip[0] <= 1'b0;
      end
      pz[0]    <= wr_z;
      pidx[0]  <= wr_idx;
      plast[0] <= wr_last;
    end
  end

  for (genvar j = 0; j < ITER; j++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        pv[j+1] <= 1'b0;
      end else if (en) begin
        pv[j+1] <= pv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pt[j] >= 0) begin
          px[j+1] <= px[j] - (py[j] >>> j);
          py[j+1] <= py[j] + (px[j] >>> j);
          pt[j+1] <= pt[j] - atan_step(5'(j));
        end else begin
          px[j+1] <= px[j] + (py[j] >>> j);
          py[j+1] <= py[j] - (px[j] >>> j);
          pt[j+1] <= pt[j] + atan_step(5'(j));
        end
        pz[j+1]    <= pz[j];
        pidx[j+1]  <= pidx[j];
        plast[j+1] <= plast[j];
        pflip[j+1] <= pflip[j];
      end
    end
  end

  // Unfold stage.
  logic                 fn_valid;
  logic signed [RW-1:0] fn_x;
  logic signed [RW-1:0] fn_y;
  logic [31:0]          fn_z;
  logic [6:0]           fn_idx;
  logic                 fn_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fn_valid <= 1'b0;
    end else if (en) begin
      fn_valid <= pv[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn_x    <= pflip[ITER] ? -px[ITER] : px[ITER];
      fn_y    <= pflip[ITER] ? -py[ITER] : py[ITER];
      fn_z    <= pz[ITER];
      fn_idx  <= pidx[ITER];
      fn_last <= plast[ITER];
    end
  end

  // Output register: center offset and saturation.
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [6:0]  out_idx;
  logic        out_last;
  logic signed [34:0] sum_x;
  logic signed [34:0] sum_y;

  always_comb begin
    sum_x = $signed({{3{center_x[31]}}, center_x}) + $signed({fn_x[RW-1], fn_x});
    sum_y = $signed({{3{center_y[31]}}, center_y}) + $signed({fn_y[RW-1], fn_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= sat32(sum_x);
      out_y    <= sat32(sum_y);
      out_z    <= fn_z;
      out_idx  <= fn_idx;
      out_last <= fn_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_idx, out_z, out_y, out_x};
  assign m_axis_tlast  = out_last;

  // Emitted index never runs past the interior point count.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (k >= 7'd1 && k <= cnt))
    else $error("point counter out of range");

  // Running remainders stay below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (acc_rt < dvs && acc_rz < dvs && rem_t < dvs && rem_z < dvs))
    else $error("interpolation remainder out of range");

  // A point leaving the block carries a nonzero index.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_idx != 7'd0))
    else $error("point index zero on output");

  // The last point of an edge enters the pipeline on the cycle the block goes idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && en && k == cnt) |=> (state == ST_IDLE && iss_valid && iss_last))
    else $error("last point not issued on leaving emit");

endmodule
